FILE: hw/rtl/elevator_target_scheduler_top_defines.svh
// Assertion macros shared by the elevator target scheduler RTL.
// Users need clk and rst_n in scope; define NO_ASSERTIONS to drop all checks.
`ifndef ELEVATOR_TARGET_SCHEDULER_TOP_DEFINES_SVH
`define ELEVATOR_TARGET_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ETS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ets: assertion failed");
// next-cycle implication
`define ETS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ets: assertion failed");
`else
`define ETS_ASSERT_IMP(lbl, ante, cons)
`define ETS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/ets_pkg.sv
// Types, codes and constants for the elevator target scheduler.
// No dependencies; used by ets_ctrl, ets_dp and the top level.
package ets_pkg;

    localparam int NUM_FLOORS_DEF = 16;
    localparam int FLOOR_W        = 5;
    localparam int RES_W          = 2;

    localparam logic ACT_CALL = 1'b0;
    localparam logic ACT_PASS = 1'b1;

    typedef enum logic [RES_W-1:0] {
        EV_NEW_TARGET   = 2'd0,
        EV_ARRIVED_CONT = 2'd1,
        EV_ARRIVED_IDLE = 2'd2
    } event_res_t;

    typedef struct packed {
        logic               action;
        logic [FLOOR_W-1:0] floor;
        logic               travel_direction;
    } req_item_t;

    typedef struct packed {
        logic [RES_W-1:0]   event_res;
        logic [FLOOR_W-1:0] event_floor;
        logic [FLOOR_W-1:0] next_target;
    } evt_item_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic emit;
    } ets_cmd_t;

    typedef struct packed {
        logic start_scan;
        logic scan_done;
        logic out_free;
    } ets_status_t;

endpackage

FILE: hw/rtl/ets_ctrl.sv
// Sequencer for the elevator target scheduler: accept, scan, emit.
// Depends on ets_pkg for the command and status structs.
module ets_ctrl
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  ets_status_t status,
    output ets_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && status.start_scan)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall     = (state_reg != ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && req_valid;
    assign cmd.scan_step = (state_reg == ST_SCAN);
    assign cmd.emit      = (state_reg == ST_EMIT) && status.out_free;

endmodule

FILE: hw/rtl/ets_dp.sv
// Datapath of the elevator target scheduler: floor bitmap, car state,
// one-floor-per-cycle target search and the result register. Uses ets_pkg.
`include "elevator_target_scheduler_top_defines.svh"
module ets_dp
    import ets_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_item_t   req,
    input  ets_cmd_t    cmd,
    output ets_status_t status,
    output logic        evt_valid,
    input  logic        evt_stall,
    output evt_item_t   evt
);

    localparam int IDXW = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(NUM_FLOORS - 1);

    // car state
    logic [NUM_FLOORS-1:0] pending_reg, pending_next;
    logic                  busy_reg, busy_next;
    logic [FLOOR_W-1:0]    current_reg, current_next;
    logic                  dir_down_reg, dir_down_next;
    logic [FLOOR_W-1:0]    target_reg, target_next;
    logic                  evt_valid_reg, evt_valid_next;

    // item and search state
    logic                  item_call_reg;
    logic [FLOOR_W-1:0]    item_floor_reg;
    logic [IDXW-1:0]       scan_idx_reg, scan_idx_next;
    logic [IDXW-1:0]       scan_start_reg, scan_start_next;
    logic                  scan_phase_reg, scan_phase_next;
    logic                  scan_down_reg, scan_down_next;
    logic                  found_reg;
    logic [FLOOR_W-1:0]    found_floor_reg;
    evt_item_t             evt_reg, evt_next;

    logic                  in_range;
    logic                  is_call;
    logic                  pass_hit;
    logic [FLOOR_W:0]      req_m1;
    logic [FLOOR_W:0]      cur_m1;
    logic [FLOOR_W:0]      tgt_m1;
    logic [IDXW-1:0]       req_idx;
    logic [IDXW-1:0]       cur_idx;
    logic [IDXW-1:0]       tgt_idx;
    logic [IDXW:0]         idx_p1;
    logic                  hit;
    logic                  at_bound;

    assign in_range = (req.floor != '0) && ({2'b00, req.floor} <= 7'(NUM_FLOORS));
    assign is_call  = (req.action == ACT_CALL);
    assign pass_hit = busy_reg && (req.floor == target_reg);
    assign req_m1   = {1'b0, req.floor} - 1'b1;
    assign cur_m1   = {1'b0, current_reg} - 1'b1;
    assign tgt_m1   = {1'b0, target_reg} - 1'b1;
    assign req_idx  = IDXW'(req_m1);
    assign cur_idx  = IDXW'(cur_m1);
    assign tgt_idx  = IDXW'(tgt_m1);
    assign idx_p1   = {1'b0, scan_idx_reg} + 1'b1;

    assign hit      = pending_reg[scan_idx_reg];
    assign at_bound = scan_down_reg ? (scan_idx_reg == '0) : (scan_idx_reg == IDX_LAST);

    assign status.start_scan = in_range && (is_call || pass_hit);
    assign status.scan_done  = hit || (at_bound && scan_phase_reg);
    assign status.out_free   = !evt_valid_reg || !evt_stall;

    always_comb
    begin
        pending_next    = pending_reg;
        busy_next       = busy_reg;
        current_next    = current_reg;
        dir_down_next   = dir_down_reg;
        target_next     = target_reg;
        evt_valid_next  = evt_valid_reg && evt_stall;
        scan_idx_next   = scan_idx_reg;
        scan_start_next = scan_start_reg;
        scan_phase_next = scan_phase_reg;
        scan_down_next  = scan_down_reg;
        evt_next        = evt_reg;

        if (cmd.load && in_range)
        begin
            if (is_call)
            begin
                pending_next[req_idx] = 1'b1;
                busy_next             = 1'b1;
                scan_idx_next         = cur_idx;
                scan_start_next       = cur_idx;
                scan_down_next        = dir_down_reg;
            end
            else if (busy_reg)
            begin
                current_next    = req.floor;
                dir_down_next   = req.travel_direction;
                scan_idx_next   = req_idx;
                scan_start_next = req_idx;
                scan_down_next  = req.travel_direction;
                if (pass_hit)
                    pending_next[req_idx] = 1'b0;
            end
            scan_phase_next = 1'b0;
        end

        if (cmd.scan_step && !status.scan_done)
        begin
            if (at_bound)
            begin
                // nothing ahead: rescan from the start the other way
                scan_phase_next = 1'b1;
                scan_idx_next   = scan_start_reg;
                scan_down_next  = !scan_down_reg;
            end
            else if (scan_down_reg)
                scan_idx_next = scan_idx_reg - 1'b1;
            else
                scan_idx_next = IDXW'(idx_p1);
        end

        if (cmd.emit)
        begin
            evt_valid_next = 1'b1;
            if (item_call_reg)
            begin
                // a called floor is always pending, so found is expected here
                evt_next.event_res   = EV_NEW_TARGET;
                evt_next.event_floor = found_reg ? found_floor_reg : item_floor_reg;
                evt_next.next_target = '0;
                target_next          = found_reg ? found_floor_reg : item_floor_reg;
            end
            else if (found_reg)
            begin
                evt_next.event_res   = EV_ARRIVED_CONT;
                evt_next.event_floor = item_floor_reg;
                evt_next.next_target = found_floor_reg;
                target_next          = found_floor_reg;
            end
            else
            begin
                evt_next.event_res   = EV_ARRIVED_IDLE;
                evt_next.event_floor = item_floor_reg;
                evt_next.next_target = '0;
                busy_next            = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            busy_reg      <= 1'b0;
            current_reg   <= FLOOR_W'(1);
            dir_down_reg  <= 1'b0;
            target_reg    <= FLOOR_W'(1);
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            busy_reg      <= busy_next;
            current_reg   <= current_next;
            dir_down_reg  <= dir_down_next;
            target_reg    <= target_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_call_reg  <= is_call;
            item_floor_reg <= req.floor;
        end
        if (cmd.scan_step && status.scan_done)
        begin
            found_reg       <= hit;
            found_floor_reg <= FLOOR_W'(idx_p1);
        end
        scan_idx_reg   <= scan_idx_next;
        scan_start_reg <= scan_start_next;
        scan_phase_reg <= scan_phase_next;
        scan_down_reg  <= scan_down_next;
        evt_reg        <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    `ETS_ASSERT_IMP(a_idle_no_pending, !busy_reg, pending_reg == '0)
    `ETS_ASSERT_NXT(a_target_pending, cmd.emit, !busy_reg || pending_reg[tgt_idx])
    `ETS_ASSERT_NXT(a_stop_clears_all, cmd.emit && !item_call_reg && !found_reg,
                    pending_reg == '0 && !busy_reg)

endmodule

FILE: hw/rtl/elevator_target_scheduler_top.sv
// Elevator target scheduler, top level.
// Channels: req (call or floor-pass beat in) and evt (scheduling result out),
// both valid/stall. A beat moves when valid is high and stall is low.
// A call marks its floor pending and yields a new-target result. A pass beat
// while busy records floor and direction; at the target it yields an arrival
// result with the next target, or a stop that returns the block to idle.
// Out-of-range floors, passes while idle and passes short of the target are
// absorbed with no result and no search.
// Flow: the accepting edge loads the search, which looks at one floor per
// cycle (first in the travel direction, then the other way) until a pending
// floor is found or both ways are done; the result register is then loaded
// once the evt register is free, and the block returns to idle for the next
// req beat.
// One beat is in work at a time; req stall is high while it is.
// A finished result sits in the evt register; a stalled receiver holds it,
// and the block may take the next req beat meanwhile, waiting only if a
// second result would overwrite the first.
// Reset: no pending floors, idle, car at floor 1 heading up, no result held.
// Uses ets_pkg, ets_ctrl and ets_dp.
module elevator_target_scheduler_top
    import ets_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_item_t evt
);

    ets_cmd_t    cmd;
    ets_status_t status;

    ets_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ets_dp #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for elevator_target_scheduler_top.
// Drives call/pass beats and checks each event beat against an in-bench schedule model.
// Depends on ets_pkg and the scheduler RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ets_pkg::*;

    localparam int NFL         = NUM_FLOORS_DEF;
    localparam int LAT_CYCLES  = 2 * NFL + 6;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 100;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      evt_valid;
    logic      evt_stall;
    evt_item_t evt;

    // schedule model state
    logic [NFL-1:0]     pend_floors = '0;
    logic               car_busy    = 1'b0;
    logic [FLOOR_W-1:0] cur_floor   = 5'd1;
    logic               dir_down    = 1'b0;
    logic [FLOOR_W-1:0] tgt_floor   = 5'd1;

    evt_item_t awaited_events[$];
    int        active_beats = 0;
    int        errors       = 0;
    int        cycle_count  = 0;
    bit        gaps_on      = 1'b0;
    bit        stalls_on    = 1'b0;

    elevator_target_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, awaited_events.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // first pending floor from the car onward in its direction, else the other way
    function automatic logic [FLOOR_W-1:0] scan_target();
        int stp;
        int idx;
        stp = dir_down ? -1 : 1;
        for (idx = int'(cur_floor) - 1; idx >= 0 && idx < NFL; idx += stp)
            if (pend_floors[idx])
                return FLOOR_W'(idx + 1);
        for (idx = int'(cur_floor) - 1; idx >= 0 && idx < NFL; idx -= stp)
            if (pend_floors[idx])
                return FLOOR_W'(idx + 1);
        return '0;
    endfunction

    function automatic void advance_schedule(req_item_t b);
        evt_item_t          ev;
        logic [FLOOR_W-1:0] nxt;
        if (b.floor < 1 || b.floor > NFL)
            return;
        if (b.action == ACT_CALL)
        begin
            car_busy = 1'b1;
            pend_floors[b.floor - 1] = 1'b1;
            nxt = scan_target();
            if (nxt == 0)
                nxt = b.floor;
            tgt_floor      = nxt;
            ev.event_res   = EV_NEW_TARGET;
            ev.event_floor = nxt;
            ev.next_target = '0;
            awaited_events = {awaited_events, ev};
            active_beats++;
            return;
        end
        if (!car_busy)
            return;
        active_beats++;
        cur_floor = b.floor;
        dir_down  = b.travel_direction;
        if (cur_floor != tgt_floor)
            return;
        pend_floors[b.floor - 1] = 1'b0;
        nxt = scan_target();
        ev.event_floor = b.floor;
        if (nxt != 0)
        begin
            tgt_floor      = nxt;
            ev.event_res   = EV_ARRIVED_CONT;
            ev.next_target = nxt;
        end
        else
        begin
            car_busy       = 1'b0;
            ev.event_res   = EV_ARRIVED_IDLE;
            ev.next_target = '0;
        end
        awaited_events = {awaited_events, ev};
    endfunction

    task automatic send_beat(logic act, logic [FLOOR_W-1:0] fl, logic dn);
        req_item_t b;
        int        gap;
        b.action           = act;
        b.floor            = fl;
        b.travel_direction = dn;
        @(negedge clk);
        req_valid = 1'b1;
        req       = b;
        do
            @(posedge clk);
        while (req_stall);
        advance_schedule(b);
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            req       = req_item_t'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender holds off until every event is back, then lets the scan settle
    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic test_ignored_beats();
        send_beat(ACT_PASS, 5'd5, DIR_UP);
        send_beat(ACT_PASS, 5'd16, DIR_DOWN);
        send_beat(ACT_PASS, 5'd0, DIR_UP);
        send_beat(ACT_CALL, 5'd0, DIR_DOWN);
        send_beat(ACT_CALL, 5'd17, DIR_UP);
        send_beat(ACT_CALL, 5'd31, DIR_DOWN);
        wait_drained();
    endtask

    task automatic test_directed_trip();
        send_beat(ACT_CALL, 5'd16, DIR_UP);
        send_beat(ACT_CALL, 5'd1, DIR_DOWN);     // car's own floor
        send_beat(ACT_PASS, 5'd1, DIR_UP);       // arrive, continue to top
        send_beat(ACT_PASS, 5'd2, DIR_UP);
        send_beat(ACT_PASS, 5'd9, DIR_UP);
        send_beat(ACT_PASS, 5'd16, DIR_UP);      // arrive, idle
        send_beat(ACT_CALL, 5'd16, DIR_UP);
        send_beat(ACT_PASS, 5'd16, DIR_DOWN);
        send_beat(ACT_CALL, 5'd4, DIR_UP);
        send_beat(ACT_CALL, 5'd10, DIR_UP);
        send_beat(ACT_CALL, 5'd10, DIR_DOWN);    // already pending
        send_beat(ACT_PASS, 5'd15, DIR_DOWN);
        send_beat(ACT_PASS, 5'd17, DIR_DOWN);    // out of range while busy
        send_beat(ACT_PASS, 5'd10, DIR_DOWN);
        send_beat(ACT_PASS, 5'd4, DIR_DOWN);
        send_beat(ACT_CALL, 5'd12, DIR_DOWN);    // nothing below, turn around
        send_beat(ACT_PASS, 5'd12, DIR_UP);
        wait_drained();
    endtask

    // car walks toward its target; calls and junk beats mixed in
    task automatic run_random_trips(int n_active, int drain_every);
        int                 goal;
        int                 last_drain;
        int                 r;
        logic               act;
        logic [FLOOR_W-1:0] fl;
        logic               dn;
        goal       = active_beats + n_active;
        last_drain = active_beats;
        while (active_beats < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                act = 1'($urandom);
                fl  = FLOOR_W'($urandom);
                dn  = 1'($urandom);
            end
            else if (!car_busy || r < 30)
            begin
                act = ACT_CALL;
                fl  = FLOOR_W'($urandom_range(1, NFL));
                dn  = 1'($urandom);
            end
            else
            begin
                act = ACT_PASS;
                if (cur_floor == tgt_floor)
                begin
                    fl = cur_floor;
                    dn = 1'($urandom);
                end
                else if (tgt_floor > cur_floor)
                begin
                    fl = cur_floor + 1'b1;
                    dn = DIR_UP;
                end
                else
                begin
                    fl = cur_floor - 1'b1;
                    dn = DIR_DOWN;
                end
            end
            send_beat(act, fl, dn);
            if (drain_every > 0 && active_beats - last_drain >= drain_every)
            begin
                wait_drained();
                last_drain = active_beats;
            end
        end
    endtask

    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_trips(150, 0);
        wait_drained();
    endtask

    task automatic test_random_trips();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_random_trips(800, 250);
    endtask

    // event receiver stall pattern
    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        evt_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!stalls_on)
                evt_stall = 1'b0;
            else if (stall_left > 0)
            begin
                evt_stall = 1'b1;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                evt_stall = 1'b0;
                run_left--;
            end
            else
            begin
                evt_stall  = 1'b0;
                stall_left = idle_len();
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 5);
            end
        end
    end

    always @(posedge clk)
    begin
        evt_item_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (awaited_events.size() == 0)
                report_mismatch($sformatf("unexpected event beat %p", evt));
            else
            begin
                want = awaited_events.pop_front();
                if (evt.event_res !== want.event_res)
                    report_mismatch($sformatf("event_res got %0d want %0d",
                                              evt.event_res, want.event_res));
                if (evt.event_floor !== want.event_floor)
                    report_mismatch($sformatf("event_floor got %0d want %0d",
                                              evt.event_floor, want.event_floor));
                if (evt.next_target !== want.next_target)
                    report_mismatch($sformatf("next_target got %0d want %0d",
                                              evt.next_target, want.next_target));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_ignored_beats();
        test_directed_trip();
        test_back_to_back();
        test_random_trips();
        wait_drained();

        if (awaited_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
